// ===== hw/rtl/cubic_bisection_root_finder_top_assert.svh =====
// Assertion helpers for the root finder top level.
// Clock and reset names are those of the top level ports.
`ifndef CUBIC_BISECTION_ROOT_FINDER_TOP_ASSERT_SVH
`define CUBIC_BISECTION_ROOT_FINDER_TOP_ASSERT_SVH

// Same-cycle implication.
`define CBR_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CBR_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cbr_pkg.sv =====
`timescale 1ns / 1ps

package cbr_pkg;

    localparam int FRAC_BITS_DEF     = 24;
    localparam int ENDPOINT_BITS_DEF = 8;

    // digit width of the shared sequential multiplier
    localparam int DIGIT_BITS = 16;

    localparam int TOL_BITS    = 31;
    localparam int ROOT_BITS   = 32;
    localparam int STATUS_BITS = 2;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    localparam logic [TOL_BITS-1:0] TOL_RESET = 31'd16777;

    // register index, taken from paddr[2]
    localparam logic REG_TOLERANCE = 1'b0;

    localparam logic [STATUS_BITS-1:0] STS_CONVERGED = 2'd0;
    localparam logic [STATUS_BITS-1:0] STS_EXACT     = 2'd1;
    localparam logic [STATUS_BITS-1:0] STS_NO_CHANGE = 2'd2;
    localparam logic [STATUS_BITS-1:0] STS_OUTSIDE   = 2'd3;

    typedef enum logic [1:0] {
        SEL_A   = 2'd0,
        SEL_B   = 2'd1,
        SEL_MID = 2'd2
    } t_sel;

    typedef enum logic [1:0] {
        FIN_NONE      = 2'd0,
        FIN_LOOP_END  = 2'd1,
        FIN_EXACT     = 2'd2,
        FIN_NO_CHANGE = 2'd3
    } t_fin;

    typedef struct packed {
        logic load;
        logic eval_start;
        t_sel eval_sel;
        logic save_sa;
        logic take_mid;
        logic set_a;
        logic set_b;
        t_fin fin;
    } t_cmd;

    typedef struct packed {
        logic wide;
        logic eval_done;
        logic eval_neg;
        logic eval_zero;
        logic sa_neg;
        logic sa_zero;
    } t_stat;

endpackage

// ===== hw/rtl/cbr_sign_eval.sv =====
`timescale 1ns / 1ps

// Sign of f(x) = x^3 + 3x + 2 for a fixed-point x, computed exactly.
// x >= 0 is always positive. For x = -m the test is
// m^3 + 3*m*S^2 against 2*S^3, S = 2^F, with m^2 and m^3 built on one
// digit-serial multiplier (DIGIT_BITS of m per cycle, top digit first).
module cbr_sign_eval #(
    parameter int W = cbr_pkg::FRAC_BITS_DEF + cbr_pkg::ENDPOINT_BITS_DEF,
    parameter int F = cbr_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [W-1:0] i_x,
    output logic                o_done,
    output logic                o_neg,
    output logic                o_zero
);

    localparam int D    = cbr_pkg::DIGIT_BITS;
    localparam int NDIG = (W + D - 1) / D;
    localparam int MPW  = NDIG * D;
    localparam int XW   = 2 * W;
    localparam int AW   = 3 * W;
    localparam int SW   = 3 * W + 1;
    localparam int CNTW = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam logic [SW-1:0] KCONST = SW'(1) << (3 * F + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SQ   = 5'b00010,
        S_CUBE = 5'b00100,
        S_SUM  = 5'b01000,
        S_CMP  = 5'b10000
    } t_state;

    t_state          r_state;
    logic [W-1:0]    r_m;
    logic [MPW-1:0]  r_y;
    logic [XW-1:0]   r_x;
    logic [AW-1:0]   r_acc;
    logic [CNTW-1:0] r_cnt;
    logic [SW-1:0]   r_sum;
    logic            r_done;
    logic            r_neg;
    logic            r_zero;

    logic [W-1:0]    w_mag;
    logic [D-1:0]    w_digit;
    logic [XW+D-1:0] w_prod;
    logic [AW-1:0]   w_acc_next;
    logic            w_last;

    assign w_mag      = (~i_x) + W'(1);
    assign w_digit    = r_y[MPW-1 -: D];
    assign w_prod     = (XW+D)'(r_x) * (XW+D)'(w_digit);
    assign w_acc_next = (r_acc << D) + AW'(w_prod);
    assign w_last     = (r_cnt == CNTW'(NDIG - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_neg   <= 1'b0;
            r_zero  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (!i_x[W-1]) begin
                            r_done <= 1'b1;
                            r_neg  <= 1'b0;
                            r_zero <= 1'b0;
                        end else begin
                            r_state <= S_SQ;
                        end
                    end
                end
                S_SQ: begin
                    if (w_last) begin
                        r_state <= S_CUBE;
                    end
                end
                S_CUBE: begin
                    if (w_last) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_done  <= 1'b1;
                    r_neg   <= (r_sum > KCONST);
                    r_zero  <= (r_sum == KCONST);
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_m   <= w_mag;
                r_y   <= MPW'(w_mag);
                r_x   <= XW'(w_mag);
                r_acc <= '0;
                r_cnt <= '0;
            end
            S_SQ: begin
                if (w_last) begin
                    // m^2 becomes the multiplicand of the second pass
                    r_x   <= w_acc_next[XW-1:0];
                    r_acc <= '0;
                    r_y   <= MPW'(r_m);
                    r_cnt <= '0;
                end else begin
                    r_acc <= w_acc_next;
                    r_y   <= r_y << D;
                    r_cnt <= r_cnt + CNTW'(1);
                end
            end
            S_CUBE: begin
                r_acc <= w_acc_next;
                r_y   <= r_y << D;
                r_cnt <= r_cnt + CNTW'(1);
            end
            S_SUM: begin
                r_sum <= SW'(r_acc) + (((SW'(r_m) << 1) + SW'(r_m)) << (2 * F));
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_neg  = r_neg;
    assign o_zero = r_zero;

endmodule

// ===== hw/rtl/cbr_datapath.sv =====
`timescale 1ns / 1ps

module cbr_datapath #(
    parameter int FRAC_BITS     = cbr_pkg::FRAC_BITS_DEF,
    parameter int ENDPOINT_BITS = cbr_pkg::ENDPOINT_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  cbr_pkg::t_cmd                        i_cmd,
    input  logic signed [ENDPOINT_BITS-1:0]      i_lower_end,
    input  logic signed [ENDPOINT_BITS-1:0]      i_upper_end,
    input  logic [cbr_pkg::TOL_BITS-1:0]         i_tolerance,
    output cbr_pkg::t_stat                       o_stat,
    output logic                                 o_done,
    output logic signed [cbr_pkg::ROOT_BITS-1:0] o_root_value,
    output logic [cbr_pkg::STATUS_BITS-1:0]      o_result_status
);

    localparam int W   = ENDPOINT_BITS + FRAC_BITS;
    localparam int DW  = ((W + 1) > cbr_pkg::TOL_BITS + 1 ? (W + 1) : cbr_pkg::TOL_BITS + 1) + 1;
    localparam int OXW = (W > cbr_pkg::ROOT_BITS) ? W : cbr_pkg::ROOT_BITS;

    logic signed [W-1:0] r_a;
    logic signed [W-1:0] r_b;
    logic signed [W-1:0] r_a0;
    logic signed [W-1:0] r_b0;
    logic signed [W-1:0] r_mid;
    logic                r_sa_neg;
    logic                r_sa_zero;
    logic                r_done;
    logic signed [cbr_pkg::ROOT_BITS-1:0]   r_root;
    logic [cbr_pkg::STATUS_BITS-1:0]        r_status;

    logic [cbr_pkg::TOL_BITS-1:0] w_tol;
    logic signed [DW-1:0]         w_diff;
    logic signed [DW-1:0]         w_tolx;
    logic signed [W:0]            w_sum;
    logic signed [W-1:0]          w_mid;
    logic signed [OXW-1:0]        w_mid_x;
    logic signed [OXW-1:0]        w_rmid_x;
    logic                         w_outside;
    logic signed [W-1:0]          w_operand;
    logic                         w_eval_done;
    logic                         w_eval_neg;
    logic                         w_eval_zero;

    // a tolerance of zero acts as one so the loop always ends
    assign w_tol  = (i_tolerance == '0) ? cbr_pkg::TOL_BITS'(1) : i_tolerance;
    assign w_diff = DW'(r_b) - DW'(r_a);
    assign w_tolx = DW'({1'b0, w_tol});

    // midpoint rounds toward minus infinity
    assign w_sum     = (W+1)'(r_a) + (W+1)'(r_b);
    assign w_mid     = w_sum[W:1];
    assign w_mid_x   = OXW'(w_mid);
    assign w_rmid_x  = OXW'(r_mid);
    assign w_outside = (w_mid < r_a0) || (w_mid > r_b0);

    always_comb begin
        case (i_cmd.eval_sel)
            cbr_pkg::SEL_A:   w_operand = r_a;
            cbr_pkg::SEL_B:   w_operand = r_b;
            cbr_pkg::SEL_MID: w_operand = w_mid;
            default:          w_operand = r_a;
        endcase
    end

    cbr_sign_eval #(
        .W (W),
        .F (FRAC_BITS)
    ) u_sign (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.eval_start),
        .i_x     (w_operand),
        .o_done  (w_eval_done),
        .o_neg   (w_eval_neg),
        .o_zero  (w_eval_zero)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a  <= {i_lower_end, {FRAC_BITS{1'b0}}};
            r_b  <= {i_upper_end, {FRAC_BITS{1'b0}}};
            r_a0 <= {i_lower_end, {FRAC_BITS{1'b0}}};
            r_b0 <= {i_upper_end, {FRAC_BITS{1'b0}}};
        end else if (i_cmd.set_a) begin
            r_a <= r_mid;
        end else if (i_cmd.set_b) begin
            r_b <= r_mid;
        end
        if (i_cmd.take_mid) begin
            r_mid <= w_mid;
        end
        if (i_cmd.save_sa) begin
            r_sa_neg  <= w_eval_neg;
            r_sa_zero <= w_eval_zero;
        end
        case (i_cmd.fin)
            cbr_pkg::FIN_LOOP_END: begin
                r_root   <= w_mid_x[cbr_pkg::ROOT_BITS-1:0];
                r_status <= w_outside ? cbr_pkg::STS_OUTSIDE : cbr_pkg::STS_CONVERGED;
            end
            cbr_pkg::FIN_EXACT: begin
                r_root   <= w_rmid_x[cbr_pkg::ROOT_BITS-1:0];
                r_status <= cbr_pkg::STS_EXACT;
            end
            cbr_pkg::FIN_NO_CHANGE: begin
                r_root   <= '0;
                r_status <= cbr_pkg::STS_NO_CHANGE;
            end
            default: begin
                r_root <= r_root;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (i_cmd.fin != cbr_pkg::FIN_NONE);
        end
    end

    assign o_stat.wide      = (w_diff > w_tolx);
    assign o_stat.eval_done = w_eval_done;
    assign o_stat.eval_neg  = w_eval_neg;
    assign o_stat.eval_zero = w_eval_zero;
    assign o_stat.sa_neg    = r_sa_neg;
    assign o_stat.sa_zero   = r_sa_zero;

    assign o_done          = r_done;
    assign o_root_value    = r_root;
    assign o_result_status = r_status;

endmodule

// ===== hw/rtl/cbr_ctrl.sv =====
`timescale 1ns / 1ps

module cbr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  cbr_pkg::t_stat i_stat,
    output cbr_pkg::t_cmd  o_cmd,
    output logic           o_busy
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_TEST   = 5'b00010,
        ST_EVAL_A = 5'b00100,
        ST_EVAL_B = 5'b01000,
        ST_EVAL_M = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_first;
    logic   n_first;
    logic   w_same_ab;
    logic   w_same_ma;

    // signs of f(a) and f(b) agree and are nonzero
    assign w_same_ab = !i_stat.eval_zero && !i_stat.sa_zero
                       && (i_stat.eval_neg == i_stat.sa_neg);
    assign w_same_ma = w_same_ab;

    always_comb begin
        n_state = r_state;
        n_first = r_first;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_first    = 1'b1;
                    n_state    = ST_TEST;
                end
            end
            ST_TEST: begin
                if (!i_stat.wide) begin
                    o_cmd.fin = cbr_pkg::FIN_LOOP_END;
                    n_state   = ST_IDLE;
                end else begin
                    o_cmd.take_mid   = 1'b1;
                    o_cmd.eval_start = 1'b1;
                    if (r_first) begin
                        o_cmd.eval_sel = cbr_pkg::SEL_A;
                        n_state        = ST_EVAL_A;
                    end else begin
                        o_cmd.eval_sel = cbr_pkg::SEL_MID;
                        n_state        = ST_EVAL_M;
                    end
                end
            end
            ST_EVAL_A: begin
                if (i_stat.eval_done) begin
                    o_cmd.save_sa    = 1'b1;
                    o_cmd.eval_start = 1'b1;
                    o_cmd.eval_sel   = cbr_pkg::SEL_B;
                    n_state          = ST_EVAL_B;
                end
            end
            ST_EVAL_B: begin
                // sign test of the ends only on the first pass; it cannot change later
                if (i_stat.eval_done) begin
                    if (w_same_ab) begin
                        o_cmd.fin = cbr_pkg::FIN_NO_CHANGE;
                        n_state   = ST_IDLE;
                    end else begin
                        o_cmd.eval_start = 1'b1;
                        o_cmd.eval_sel   = cbr_pkg::SEL_MID;
                        n_state          = ST_EVAL_M;
                    end
                end
            end
            ST_EVAL_M: begin
                if (i_stat.eval_done) begin
                    n_first = 1'b0;
                    if (i_stat.eval_zero) begin
                        o_cmd.fin = cbr_pkg::FIN_EXACT;
                        n_state   = ST_IDLE;
                    end else if (w_same_ma) begin
                        o_cmd.set_a = 1'b1;
                        n_state     = ST_TEST;
                    end else begin
                        o_cmd.set_b = 1'b1;
                        n_state     = ST_TEST;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// ===== hw/rtl/cubic_bisection_root_finder_top.sv =====
`timescale 1ns / 1ps
// Bisection root finder for x^3 + 3x + 2 over integer ends [lower, upper], result
// in signed fixed point with FRAC_BITS fraction bits. Pulse start while busy is low;
// busy stays high until the single result beat, which sits on o_root_value and
// o_result_status for exactly one cycle with o_done high and cannot be held off,
// so it must be captured then. Each halving takes one interval test in ST_TEST and the
// exact sign evaluation of the midpoint, which for a negative midpoint runs the shared
// 16-bit-digit multiplier that forms m^2 and then m^3. The first halving also evaluates
// both ends. The tolerance register (byte address 0) may only be written while
// busy is low.

`include "cubic_bisection_root_finder_top_assert.svh"

module cubic_bisection_root_finder_top #(
    parameter int FRAC_BITS     = cbr_pkg::FRAC_BITS_DEF,
    parameter int ENDPOINT_BITS = cbr_pkg::ENDPOINT_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic signed [ENDPOINT_BITS-1:0]          i_lower_end,
    input  logic signed [ENDPOINT_BITS-1:0]          i_upper_end,
    output logic                                     o_done,
    output logic signed [cbr_pkg::ROOT_BITS-1:0]     o_root_value,
    output logic [cbr_pkg::STATUS_BITS-1:0]          o_result_status,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [cbr_pkg::APB_ADDR_BITS-1:0]        paddr,
    input  logic [cbr_pkg::APB_DATA_BITS-1:0]        pwdata,
    output logic [cbr_pkg::APB_DATA_BITS-1:0]        prdata,
    output logic                                     pready
);

    logic [cbr_pkg::TOL_BITS-1:0] r_tolerance;
    logic                         w_cfg_wr;
    cbr_pkg::t_cmd                w_cmd;
    cbr_pkg::t_stat               w_stat;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[2] == cbr_pkg::REG_TOLERANCE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= cbr_pkg::TOL_RESET;
        end else if (w_cfg_wr) begin
            r_tolerance <= pwdata[cbr_pkg::TOL_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == cbr_pkg::REG_TOLERANCE)
                    ? cbr_pkg::APB_DATA_BITS'(r_tolerance) : '0;

    cbr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    cbr_datapath #(
        .FRAC_BITS     (FRAC_BITS),
        .ENDPOINT_BITS (ENDPOINT_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_lower_end     (i_lower_end),
        .i_upper_end     (i_upper_end),
        .i_tolerance     (r_tolerance),
        .o_stat          (w_stat),
        .o_done          (o_done),
        .o_root_value    (o_root_value),
        .o_result_status (o_result_status)
    );

    `CBR_CHECK_NOW(a_done_when_idle, o_done, !busy, "result beat while still busy")
    `CBR_CHECK_NEXT(a_accept_goes_busy, start && !busy, busy, "accepted item did not raise busy")
    `CBR_CHECK_NEXT(a_single_beat, o_done, !o_done, "two result beats in a row")
    `CBR_CHECK_NOW(a_no_change_zero, o_done && (o_result_status == cbr_pkg::STS_NO_CHANGE), o_root_value == '0, "no sign change with nonzero root")

endmodule
